// ===== rtl/core/ute_pkg.sv =====
// Constants and month table for the UTC date to epoch seconds converter.
package ute_pkg;

   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned EPOCH_W    = 39;
   localparam int unsigned DAYS_W     = 24;
   localparam int unsigned DSEC_W     = 40;
   localparam int unsigned SOD_W      = 17;

   // year - 1 = year_from_1900 + 1899
   localparam logic signed [14:0] YEAR_M1_BIAS  = 15'sd1899;
   localparam logic signed [14:0] EPOCH_YEAR_OFS = 15'sd70;
   // keeps floor(year-1, 4) positive before the divide by 25
   localparam logic signed [12:0] Q4_OFS        = 13'sd1600;
   localparam logic signed [9:0]  Q100_OFS      = 10'sd64;
   localparam logic [12:0]        RECIP25       = 13'd5243;  // ceil(2^17 / 25)
   localparam int unsigned        RECIP_SHIFT   = 17;
   localparam logic signed [12:0] DIV25_MUL     = 13'sd25;
   localparam logic signed [12:0] REM_LAST      = 13'sd24;
   // leap days before 1970 with the same offset: 492 - 19 + 4
   localparam logic signed [12:0] LEAPS_1970    = 13'sd477;
   localparam logic signed [DAYS_W-1:0] DAYS_PER_YEAR = 24'sd365;
   localparam logic signed [DSEC_W-1:0] SECS_PER_DAY  = 40'sd86400;
   localparam logic [SOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
   localparam logic [SOD_W-1:0]   SECS_PER_MIN  = 17'd60;
   localparam logic [3:0]         MONTH_LAST    = 4'd11;
   localparam logic [3:0]         MONTH_MARCH   = 4'd2;

   function automatic logic [8:0] days_before_month(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/utc_date_to_epoch_seconds.sv =====
// Five-stage pipeline that converts a broken-down UTC date and time to epoch seconds.

// Takes one beat per clock while the output is not held and returns one result beat
// per input, in order. The five register stages (year divide by reciprocal, leap count,
// day count, day-to-seconds multiply, final add) advance together; when the output beat
// is held the whole pipeline holds, so req_tready follows rsp_tready while the output
// stage is full. Years use the proleptic Gregorian rule. Day, hour, minute and second
// add linearly without normalization. A month index above 11 sets rsp_tuser and forces
// the seconds to zero.
module utc_date_to_epoch_seconds
   import ute_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // year_from_1900[13:0], month_index[17:14], day_of_month[22:18],
   // hour_of_day[27:23], minute_of_hour[33:28], second_of_minute[39:34]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // epoch_seconds[38:0], zero pad[39]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // month_error[0]
   output logic                  rsp_tuser
);

   logic       advance;
   logic [4:0] vld_ff;

   // stage 1 inputs
   logic signed [13:0] yoff;
   logic [3:0]         month;
   logic [4:0]         mday;
   logic signed [14:0] ym1;
   logic signed [12:0] q4_in;
   logic [12:0]        div_n;
   logic [25:0]        prod_in;
   logic [SOD_W-1:0]   sod_in;

   logic signed [12:0] s1_q4_ff;
   logic [1:0]         s1_ylo_ff;
   logic [25:0]        s1_prod_ff;
   logic signed [13:0] s1_yoff_ff;
   logic [3:0]         s1_month_ff;
   logic [4:0]         s1_mday_ff;
   logic [SOD_W-1:0]   s1_sod_ff;

   // stage 2
   logic signed [9:0]  q100;
   logic signed [12:0] rem25;
   logic               leap_in;
   logic signed [12:0] leapdays_in;

   logic               s2_leap_ff;
   logic signed [12:0] s2_leapdays_ff;
   logic signed [13:0] s2_yoff_ff;
   logic [3:0]         s2_month_ff;
   logic [4:0]         s2_mday_ff;
   logic [SOD_W-1:0]   s2_sod_ff;

   // stage 3
   logic signed [14:0]       yrs;
   logic [DAYS_W-1:0]        leap_add;
   logic signed [DAYS_W-1:0] days_in;
   logic                     merr_in;

   logic signed [DAYS_W-1:0] s3_days_ff;
   logic                     s3_merr_ff;
   logic [SOD_W-1:0]         s3_sod_ff;

   // stage 4
   logic signed [DSEC_W-1:0] dsec_in;
   logic signed [DSEC_W-1:0] s4_dsec_ff;
   logic                     s4_merr_ff;
   logic [SOD_W-1:0]         s4_sod_ff;

   // stage 5
   logic [EPOCH_W-1:0] epoch_in;
   logic [EPOCH_W-1:0] s5_epoch_ff;
   logic               s5_merr_ff;

   // hold every stage while the output beat waits
   assign advance    = !vld_ff[4] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      yoff    = signed'(req_tdata[13:0]);
      month   = req_tdata[17:14];
      mday    = req_tdata[22:18];
      ym1     = 15'(yoff) + YEAR_M1_BIAS;
      q4_in   = ym1[14:2];
      div_n   = 13'(q4_in + Q4_OFS);
      prod_in = 26'(div_n) * 26'(RECIP25);
      sod_in  = 17'(req_tdata[27:23]) * SECS_PER_HOUR
              + 17'(req_tdata[33:28]) * SECS_PER_MIN
              + 17'(req_tdata[39:34]);
   end

   always_comb begin
      q100 = signed'({1'b0, s1_prod_ff[25:RECIP_SHIFT]}) - Q100_OFS;
      rem25 = s1_q4_ff - 13'(q100) * DIV25_MUL;
      // year divisible by 4; century years only when divisible by 400
      leap_in = (s1_ylo_ff == 2'b11) && ((rem25 != REM_LAST) || (q100[1:0] == 2'b11));
      leapdays_in = s1_q4_ff - 13'(q100) + 13'(q100 >>> 2) - LEAPS_1970;
   end

   always_comb begin
      yrs      = 15'(s2_yoff_ff) - EPOCH_YEAR_OFS;
      leap_add = (s2_leap_ff && (s2_month_ff >= MONTH_MARCH)) ? 24'd1 : 24'd0;
      days_in  = 24'(yrs) * DAYS_PER_YEAR + 24'(s2_leapdays_ff)
               + signed'({15'd0, days_before_month(s2_month_ff)})
               + signed'(leap_add) + signed'({19'd0, s2_mday_ff}) - 24'sd1;
      merr_in  = s2_month_ff > MONTH_LAST;
   end

   always_comb begin
      dsec_in = 40'(s3_days_ff) * SECS_PER_DAY;
   end

   always_comb begin
      if (s4_merr_ff) begin
         epoch_in = '0;
      end else begin
         epoch_in = EPOCH_W'(s4_dsec_ff + signed'({23'd0, s4_sod_ff}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[3:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_q4_ff       <= q4_in;
         s1_ylo_ff      <= ym1[1:0];
         s1_prod_ff     <= prod_in;
         s1_yoff_ff     <= yoff;
         s1_month_ff    <= month;
         s1_mday_ff     <= mday;
         s1_sod_ff      <= sod_in;

         s2_leap_ff     <= leap_in;
         s2_leapdays_ff <= leapdays_in;
         s2_yoff_ff     <= s1_yoff_ff;
         s2_month_ff    <= s1_month_ff;
         s2_mday_ff     <= s1_mday_ff;
         s2_sod_ff      <= s1_sod_ff;

         s3_days_ff     <= days_in;
         s3_merr_ff     <= merr_in;
         s3_sod_ff      <= s2_sod_ff;

         s4_dsec_ff     <= dsec_in;
         s4_merr_ff     <= s3_merr_ff;
         s4_sod_ff      <= s3_sod_ff;

         s5_epoch_ff    <= epoch_in;
         s5_merr_ff     <= s4_merr_ff;
      end
   end

   assign rsp_tvalid = vld_ff[4];
   assign rsp_tdata  = {1'b0, s5_epoch_ff};
   assign rsp_tuser  = s5_merr_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("month error beat carries nonzero seconds");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during a stall");

   a_accept_enter: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat missing from the first stage");

   a_merr_flow: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[3] |=> rsp_tuser == $past(s4_merr_ff))
      else $error("month error flag lost on the way to the output");

endmodule

// ===== test/tb_utc_date_to_epoch_seconds.sv =====
// Self-checking testbench for the UTC date to epoch seconds converter.
module tb_utc_date_to_epoch_seconds;
   import ute_pkg::*;

   localparam int    N_RANDOM    = 950;
   localparam int    MODE1_AT    = 325;
   localparam int    MODE2_AT    = 650;
   localparam int    DRAIN_AT    = 500;
   localparam int    HOLD_AT     = 700;
   localparam int    HOLD_CYCLES = 80;
   localparam int    TAIL_CYCLES = 20;
   localparam int    CYCLE_LIMIT = 200000;
   localparam longint YEAR_BASE    = 1900;
   localparam longint EPOCH_YEAR   = 1970;
   localparam longint DAYS_IN_YEAR = 365;
   localparam longint SECS_IN_DAY  = 86400;
   localparam longint SECS_IN_HOUR = 3600;
   localparam longint SECS_IN_MIN  = 60;
   localparam int CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   // first field in the high bits, as on req_tdata
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year_ofs;
   } date_item_type;

   typedef struct packed {
      logic        month_error;
      logic [38:0] seconds;
   } epoch_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   date_item_type    pending_q [$];
   epoch_result_type expected_q [$];
   date_item_type    cur_item;
   int               sent_count = 0;
   int               rcvd_count = 0;
   int               fail_count = 0;
   int               hold_left = 0;
   bit               hold_done = 1'b0;

   utc_date_to_epoch_seconds u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic bit is_leap(longint y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   // leap days in years before y, shifted by a constant that cancels out
   function automatic longint leaps_upto(longint y);
      return floor_div(y - 1, 4) - floor_div(y - 1, 100) + floor_div(y - 1, 400);
   endfunction

   function automatic epoch_result_type predict_epoch(date_item_type d);
      epoch_result_type r;
      longint           yr;
      longint           days;
      longint           total;
      r = '0;
      if (d.month > MONTH_LAST) begin
         r.month_error = 1'b1;
         return r;
      end
      yr = longint'($signed(d.year_ofs)) + YEAR_BASE;
      days = (yr - EPOCH_YEAR) * DAYS_IN_YEAR + leaps_upto(yr) - leaps_upto(EPOCH_YEAR)
             + CUM_DAYS[d.month];
      if (d.month >= MONTH_MARCH && is_leap(yr)) days = days + 1;
      days = days + longint'(d.day) - 1;
      total = days * SECS_IN_DAY + longint'(d.hour) * SECS_IN_HOUR
              + longint'(d.minute) * SECS_IN_MIN + longint'(d.second);
      r.seconds = total[38:0];
      return r;
   endfunction

   function automatic int tx_idle_pct(int n);
      if (n < MODE1_AT) return 18;
      if (n < MODE2_AT) return 47;
      return 0;
   endfunction

   function automatic int rx_idle_pct(int n);
      if (n < MODE1_AT) return 47;
      if (n < MODE2_AT) return 18;
      return 0;
   endfunction

   task automatic add_date(int y, int m, int d, int h, int mi, int s);
      date_item_type it;
      it.year_ofs = 14'(y);
      it.month    = 4'(m);
      it.day      = 5'(d);
      it.hour     = 5'(h);
      it.minute   = 6'(mi);
      it.second   = 6'(s);
      pending_q.push_back(it);
   endtask

   task automatic report_mismatch(string msg);
      $display("ERROR: beat %0d: %s", rcvd_count, msg);
      fail_count++;
   endtask

   // driver: hold the beat until taken, then pick the next one or idle
   always @(posedge clock) begin
      bit offer;
      int n_sent;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         n_sent = sent_count;
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_epoch(cur_item));
            n_sent = n_sent + 1;
            sent_count <= n_sent;
         end
         if (!(req_tvalid && !req_tready)) begin
            offer = pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct(n_sent);
            // let the pipeline drain once before going on
            if (n_sent == DRAIN_AT && expected_q.size() != 0) offer = 1'b0;
            if (offer) begin
               cur_item = pending_q.pop_front();
               req_tdata  <= cur_item;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      epoch_result_type got;
      epoch_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.seconds     = rsp_tdata[EPOCH_W-1:0];
            got.month_error = rsp_tuser;
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected");
            end else begin
               want = expected_q.pop_front();
               if (got.seconds !== want.seconds)
                  report_mismatch($sformatf("epoch_seconds got %0d want %0d",
                                            $signed(got.seconds), $signed(want.seconds)));
               if (got.month_error !== want.month_error)
                  report_mismatch($sformatf("month_error got %0b want %0b",
                                            got.month_error, want.month_error));
            end
            rcvd_count++;
         end
         rsp_tready <= hold_left == 0 && $urandom_range(99) >= rx_idle_pct(sent_count);
      end
   end

   initial begin
      int y;
      int m;
      int d;
      int h;
      int mi;
      int s;
      // epoch, extremes of every field, leap rules, leap second
      add_date(70, 0, 1, 0, 0, 0);
      add_date(69, 11, 31, 23, 59, 59);
      add_date(-8192, 0, 0, 0, 0, 0);
      add_date(8191, 11, 31, 31, 63, 63);
      add_date(-1900, 1, 29, 12, 0, 0);
      add_date(-1900, 2, 1, 0, 0, 0);
      add_date(-1901, 11, 31, 23, 59, 59);
      add_date(100, 1, 29, 0, 0, 0);
      add_date(100, 2, 1, 0, 0, 0);
      add_date(200, 1, 28, 0, 0, 0);
      add_date(200, 2, 1, 0, 0, 0);
      add_date(72, 6, 30, 23, 59, 60);
      add_date(8099, 11, 31, 23, 59, 60);
      // every month, the top four invalid
      for (int k = 0; k < 16; k++) add_date(124, k, 15, 10, 30, 45);
      add_date(-1, 15, 31, 31, 63, 63);

      for (int k = 0; k < N_RANDOM; k++) begin
         case ($urandom_range(9))
            0, 1:    y = int'($urandom_range(16383)) - 8192;
            2, 3:    y = int'($urandom_range(140)) + 0;
            default: y = int'($urandom_range(9999)) - 1900;
         endcase
         m  = ($urandom_range(9) == 0) ? $urandom_range(15, 12) : $urandom_range(11);
         d  = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(31, 1);
         h  = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(23);
         mi = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(59);
         s  = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(60);
         add_date(y, m, d, h, mi, s);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
   end

endmodule
